/* hw/rtl/touch_sample_qualifier_core_defines.svh */
// Assertion helpers for the touch sample qualifier.
// Each macro expects clk and rst_n in scope.
`ifndef TOUCH_SAMPLE_QUALIFIER_CORE_DEFINES_SVH
`define TOUCH_SAMPLE_QUALIFIER_CORE_DEFINES_SVH

// Same-cycle implication.
`define TSQ_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("touch sample qualifier check failed");

// Next-cycle implication.
`define TSQ_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("touch sample qualifier check failed");

`endif

/* hw/rtl/tsq_pkg.sv */
`default_nettype none

package tsq_pkg;

    // register file
    localparam int REG_W      = 12;
    localparam int NUM_REGS   = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int REG_ADDR_W = 3;

    localparam logic [REG_ADDR_W-1:0] REG_X_CAL_LOW   = 3'd0;
    localparam logic [REG_ADDR_W-1:0] REG_X_CAL_HIGH  = 3'd1;
    localparam logic [REG_ADDR_W-1:0] REG_Y_CAL_LOW   = 3'd2;
    localparam logic [REG_ADDR_W-1:0] REG_Y_CAL_HIGH  = 3'd3;
    localparam logic [REG_ADDR_W-1:0] REG_X_SPAN      = 3'd4;
    localparam logic [REG_ADDR_W-1:0] REG_Y_SPAN      = 3'd5;
    localparam logic [REG_ADDR_W-1:0] REG_TOUCH_FLOOR = 3'd6;
    localparam logic [REG_ADDR_W-1:0] REG_MAX_DIFF    = 3'd7;

    localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
        12'd200, 12'd3900, 12'd200, 12'd3900, 12'd240, 12'd320, 12'd50, 12'd10
    };

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_PEN = 2'd1,
        ST_CAL = 2'd2
    } status_t;

    // divider: quotient is known to be below span, so 12 bits
    localparam int QW        = 12;
    localparam int DIV_NUM_W = 2 * QW;
    localparam int DIV_CNT_W = 4;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [QW-1:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic          done;
        logic [QW-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/touch_sample_qualifier_core.sv */
// Touch sample qualifier: takes raw ADC samples for one panel axis, sorts each
// group of GROUP_SIZE samples in a row of sorter cells as they arrive, and
// averages the middle four into a group value. Two group values in a row must
// both reach the touch threshold register and differ by at most max_diff; their
// mean is then scaled to screen units, span*(m-cal_low)/(cal_high-cal_low),
// truncated toward zero and clamped to 0..span. A pen-up transfer aborts the
// attempt at once and returns status 1; equal calibration end points return
// status 2; changing the axis restarts the group. While a group fills, only a
// waiting result held by out_stall holds off the input. The transfer that
// closes a group holds off the input while the group value is qualified and,
// for a pair that qualifies, while the operands are prepared; when the result
// needs division (not for a calibration fault or a clamped ratio), also while
// the multiply is formed and the bit-serial divider finds the twelve quotient
// bits, one per cycle, and registers the last. A result waiting in the output
// register while out_stall is high, a pen-up report for example, also holds off
// the next input. Configuration writes are always ready and take effect at
// once; write them while idle.
`default_nettype none
`include "touch_sample_qualifier_core_defines.svh"

module touch_sample_qualifier_core #(
    parameter int GROUP_SIZE  = 10,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // sample input
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [11:0]                     sample,
    input  logic                            axis,
    input  logic                            pen_up,
    // result output
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [11:0]                     position,
    output logic                            out_axis,
    output logic [1:0]                      status,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tsq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsq_pkg::REG_W-1:0]       cfg_data
);

    import tsq_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int CW  = $clog2(GROUP_SIZE);
    localparam int MID = GROUP_SIZE / 2 - 2;
    // width that holds both a group value and a register
    localparam int MW  = (SAMPLE_BITS > REG_W) ? SAMPLE_BITS : REG_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_GRP   = 5'b00010,
        S_SCALE = 5'b00100,
        S_MUL   = 5'b01000,
        S_DIV   = 5'b10000
    } state_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [REG_W-1:0] cfg_reg [NUM_REGS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= REG_RESET[i];
            end
        end
        else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS)))
        begin
            cfg_reg[cfg_index[REG_ADDR_W-1:0]] <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [SB-1:0]   first_reg, first_next;
    logic            have_first_reg, have_first_next;
    logic            cur_axis_reg, cur_axis_next;

    logic            out_valid_reg, out_valid_next;
    logic [11:0]     position_reg, position_next;
    logic            out_axis_reg, out_axis_next;
    status_t         status_reg, status_next;
    logic            out_load;

    // scaling operands
    logic [SB-1:0]   m_reg, m_next;
    logic [QW-1:0]   a_reg, a_next;
    logic [QW-1:0]   d_reg, d_next;
    logic [QW-1:0]   span_reg, span_next;

    // ------------------------------------------------------------------
    // input side and sorter chain
    // ------------------------------------------------------------------
    logic                  in_acc;
    logic                  ins_en;
    logic                  axis_chg;
    logic [CW-1:0]         eff_cnt;
    logic [SB-1:0]         s_in;
    logic [GROUP_SIZE-1:0] cell_gt;
    logic [GROUP_SIZE-1:0] occ;
    logic [SB-1:0]         cell_val [GROUP_SIZE];

    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_acc   = in_valid && !in_stall;
    assign ins_en   = in_acc && !pen_up;
    assign axis_chg = axis != cur_axis_reg;
    // an axis change drops whatever the group held
    assign eff_cnt  = axis_chg ? '0 : count_reg;
    assign s_in     = SB'(sample);

    for (genvar i = 0; i < GROUP_SIZE; i++)
    begin : g_cell
        logic          pg;
        logic [SB-1:0] pv;
        if (i == 0)
        begin : g_head
            assign pg = 1'b0;
            assign pv = '0;
        end
        else
        begin : g_link
            assign pg = cell_gt[i-1];
            assign pv = cell_val[i-1];
        end
        assign occ[i] = CW'(i) < eff_cnt;
        tsq_cell #(
            .W (SB)
        ) u_cell (
            .clk      (clk),
            .ins_en   (ins_en),
            .new_val  (s_in),
            .occupied (occ[i]),
            .prev_gt  (pg),
            .prev_val (pv),
            .gt       (cell_gt[i]),
            .val      (cell_val[i])
        );
    end

    // ------------------------------------------------------------------
    // group value and qualification
    // ------------------------------------------------------------------
    logic [SB+1:0] mid_sum;
    logic [SB-1:0] gval;
    logic [SB-1:0] gdiff;
    logic [SB:0]   mean_sum;

    assign mid_sum  = (SB+2)'(cell_val[MID]) + (SB+2)'(cell_val[MID+1])
                    + (SB+2)'(cell_val[MID+2]) + (SB+2)'(cell_val[MID+3]);
    assign gval     = mid_sum[SB+1:2];
    assign gdiff    = (gval > first_reg) ? gval - first_reg : first_reg - gval;
    assign mean_sum = {1'b0, gval} + {1'b0, first_reg};

    // ------------------------------------------------------------------
    // scaling operands
    // ------------------------------------------------------------------
    logic [REG_W-1:0]  lo_sel, hi_sel, span_sel;
    logic signed [MW:0]    nd;
    logic signed [REG_W:0] dd;
    logic [MW-1:0]     a_full;
    logic [QW-1:0]     d_abs;

    assign lo_sel   = cur_axis_reg ? cfg_reg[REG_Y_CAL_LOW]  : cfg_reg[REG_X_CAL_LOW];
    assign hi_sel   = cur_axis_reg ? cfg_reg[REG_Y_CAL_HIGH] : cfg_reg[REG_X_CAL_HIGH];
    assign span_sel = cur_axis_reg ? cfg_reg[REG_Y_SPAN]     : cfg_reg[REG_X_SPAN];
    assign nd       = $signed({1'b0, MW'(m_reg)}) - $signed({1'b0, MW'(lo_sel)});
    assign dd       = $signed({1'b0, hi_sel}) - $signed({1'b0, lo_sel});
    assign a_full   = nd[MW] ? MW'(-nd) : MW'(nd);
    assign d_abs    = dd[REG_W] ? QW'(-dd) : QW'(dd);

    // ------------------------------------------------------------------
    // divider
    // ------------------------------------------------------------------
    div_req_t div_req;
    div_rsp_t div_rsp;

    assign div_req.start    = state_reg == S_MUL;
    assign div_req.dividend = DIV_NUM_W'(span_reg) * DIV_NUM_W'(a_reg);
    assign div_req.divisor  = d_reg;

    tsq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        first_next      = first_reg;
        have_first_next = have_first_reg;
        cur_axis_next   = cur_axis_reg;
        m_next          = m_reg;
        a_next          = a_reg;
        d_next          = d_reg;
        span_next       = span_reg;
        out_load        = 1'b0;
        position_next   = position_reg;
        out_axis_next   = out_axis_reg;
        status_next     = status_reg;
        // drop the held result once it is transferred
        out_valid_next  = out_valid_reg && out_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && pen_up)
                begin
                    // abort the attempt and report the release
                    count_next      = '0;
                    have_first_next = 1'b0;
                    cur_axis_next   = axis;
                    out_load        = 1'b1;
                    position_next   = '0;
                    out_axis_next   = axis;
                    status_next     = ST_PEN;
                end
                else if (in_acc)
                begin
                    cur_axis_next = axis;
                    if (axis_chg)
                    begin
                        have_first_next = 1'b0;
                    end
                    if (eff_cnt == CW'(GROUP_SIZE - 1))
                    begin
                        count_next = '0;
                        state_next = S_GRP;
                    end
                    else
                    begin
                        count_next = CW'(eff_cnt + CW'(1));
                    end
                end
            end
            S_GRP:
            begin
                state_next = S_IDLE;
                if (MW'(gval) < MW'(cfg_reg[REG_TOUCH_FLOOR]))
                begin
                    have_first_next = 1'b0;
                end
                else if (!have_first_reg)
                begin
                    first_next      = gval;
                    have_first_next = 1'b1;
                end
                else
                begin
                    have_first_next = 1'b0;
                    if (MW'(gdiff) <= MW'(cfg_reg[REG_MAX_DIFF]))
                    begin
                        m_next     = mean_sum[SB:1];
                        state_next = S_SCALE;
                    end
                end
            end
            S_SCALE:
            begin
                state_next    = S_IDLE;
                position_next = '0;
                out_axis_next = cur_axis_reg;
                status_next   = ST_OK;
                if (dd == '0)
                begin
                    out_load    = 1'b1;
                    status_next = ST_CAL;
                end
                else if (nd[MW] != dd[REG_W])
                begin
                    // opposite signs: quotient at or below zero, clamp to zero
                    out_load = 1'b1;
                end
                else if (a_full >= MW'(d_abs))
                begin
                    // ratio at least one: clamp to span
                    out_load      = 1'b1;
                    position_next = span_sel;
                end
                else
                begin
                    a_next     = a_full[QW-1:0];
                    d_next     = d_abs;
                    span_next  = span_sel;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    out_load      = 1'b1;
                    position_next = div_rsp.quotient;
                    out_axis_next = cur_axis_reg;
                    status_next   = ST_OK;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            first_reg      <= '0;
            have_first_reg <= 1'b0;
            cur_axis_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            first_reg      <= first_next;
            have_first_reg <= have_first_next;
            cur_axis_reg   <= cur_axis_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        position_reg <= position_next;
        out_axis_reg <= out_axis_next;
        status_reg   <= status_next;
        m_reg        <= m_next;
        a_reg        <= a_next;
        d_reg        <= d_next;
        span_reg     <= span_next;
    end

    assign out_valid = out_valid_reg;
    assign position  = position_reg;
    assign out_axis  = out_axis_reg;
    assign status    = status_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `TSQ_ASSERT_NEXT(a_group_close, ins_en && (eff_cnt == CW'(GROUP_SIZE - 1)), state_reg == S_GRP)
    `TSQ_ASSERT_NOW(a_div_in_state, div_rsp.done, state_reg == S_DIV)
    `TSQ_ASSERT_NOW(a_out_free, out_load, !out_valid_reg || !out_stall)
    `TSQ_ASSERT_NEXT(a_pen_report, in_acc && pen_up, out_valid_reg && (status_reg == ST_PEN))

endmodule

`default_nettype wire

/* hw/rtl/tsq_cell.sv */
`default_nettype none

// One slot of the insertion sorter. Holds one sample; on insert it either
// keeps its value, takes the new sample, or takes its lower neighbor's value.
module tsq_cell #(
    parameter int W = 12
) (
    input  logic         clk,
    input  logic         ins_en,
    input  logic [W-1:0] new_val,
    input  logic         occupied,
    input  logic         prev_gt,
    input  logic [W-1:0] prev_val,
    output logic         gt,
    output logic [W-1:0] val
);

    logic [W-1:0] value_reg;
    logic [W-1:0] value_next;

    // empty slots act as larger than anything
    assign gt         = !occupied || (new_val < value_reg);
    assign value_next = prev_gt ? prev_val : new_val;
    assign val        = value_reg;

    always_ff @(posedge clk)
    begin
        if (ins_en && gt)
        begin
            value_reg <= value_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/tsq_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle. The upper half of the
// dividend must be below the divisor.
module tsq_div (
    input  logic              clk,
    input  logic              rst_n,
    input  tsq_pkg::div_req_t req,
    output tsq_pkg::div_rsp_t rsp
);

    import tsq_pkg::*;

    logic [QW-1:0]        rem_reg;
    logic [QW-1:0]        rem_next;
    logic [QW-1:0]        sh_reg;
    logic [QW-1:0]        sh_next;
    logic [QW-1:0]        den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [QW:0]          trial;
    logic                 ge;

    assign trial = {rem_reg, sh_reg[QW-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.dividend[DIV_NUM_W-1:QW];
            sh_next   = req.dividend[QW-1:0];
            cnt_next  = DIV_CNT_W'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? QW'(trial - {1'b0, den_reg}) : trial[QW-1:0];
            sh_next  = {sh_reg[QW-2:0], ge};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        if (req.start)
        begin
            den_reg <= req.divisor;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = sh_reg;

endmodule

`default_nettype wire
